[design/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the stable priority queue
// Sizes, operation codes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 16;
    localparam int VALUE_W   = 32;
    localparam int PRIO_IN_W = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [PRIO_BITS-1:0]      t_prio;
    typedef logic [CNT_W-1:0]          t_count;

    // controller -> datapath
    typedef struct packed {
        logic load;  // capture the incoming item
        logic exec;  // apply the held item and load the result register
    } t_dp_cmd;

endpackage

`default_nettype wire

[design/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl: sequencing for the stable priority queue
// Takes one item, applies it once the result register is free, tracks o_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output spq_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // result register can take a new result this cycle
    assign out_free   = !r_out_valid || i_ready;

    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec = (r_state == S_EXEC) && out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

[design/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath: sorted slot array and result register
// Every slot compares against the held priority in parallel; insert and pop
// each shift the array by one place.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire spq_pkg::t_dp_cmd                  i_cmd,
    input  wire logic                              i_func,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] i_value,
    input  wire logic [spq_pkg::PRIO_IN_W-1:0]     i_priority_req,
    output logic signed [spq_pkg::VALUE_W-1:0]     o_popped_value,
    output logic                                   o_popped_valid,
    output logic                                   o_empty_error,
    output logic                                   o_full_error,
    output logic signed [spq_pkg::VALUE_W-1:0]     o_head_value,
    output logic [spq_pkg::CNT_W-1:0]              o_entry_count
);

    localparam int D = spq_pkg::DEPTH;

    // held item
    logic            r_func;
    spq_pkg::t_value r_in_value;
    spq_pkg::t_prio  r_in_prio;

    // slot array
    spq_pkg::t_value r_val [D];
    spq_pkg::t_prio  r_pri [D];
    spq_pkg::t_value n_val [D];
    spq_pkg::t_prio  n_pri [D];
    spq_pkg::t_count r_count, n_count;

    // result register
    spq_pkg::t_value r_popped_value, n_popped_value;
    logic            r_popped_valid, n_popped_valid;
    logic            r_empty_error,  n_empty_error;
    logic            r_full_error,   n_full_error;
    spq_pkg::t_value r_head_value,   n_head_value;
    spq_pkg::t_count r_entry_count;

    logic [D-1:0] le;       // slot holds an entry that stays ahead of the new one
    logic [D-1:0] le_prev;  // same flag for the slot before
    logic         full;
    logic         empty;

    assign full  = (r_count == spq_pkg::t_count'(D));
    assign empty = (r_count == '0);

    always_comb begin
        for (int i = 0; i < D; i++) begin
            le[i] = (spq_pkg::t_count'(i) < r_count) && (r_pri[i] <= r_in_prio);
        end
        le_prev[0] = 1'b1;
        for (int i = 1; i < D; i++) begin
            le_prev[i] = le[i-1];
        end
    end

    always_comb begin
        for (int i = 0; i < D; i++) begin
            n_val[i] = r_val[i];
            n_pri[i] = r_pri[i];
        end
        n_count        = r_count;
        n_popped_value = '0;
        n_popped_valid = 1'b0;
        n_empty_error  = 1'b0;
        n_full_error   = 1'b0;
        if (r_func == spq_pkg::FUNC_PUSH) begin
            if (full) begin
                n_full_error = 1'b1;
            end else begin
                for (int i = 0; i < D; i++) begin
                    if (!le[i]) begin
                        if (le_prev[i]) begin
                            n_val[i] = r_in_value;
                            n_pri[i] = r_in_prio;
                        end else begin
                            n_val[i] = r_val[(i + D - 1) % D];
                            n_pri[i] = r_pri[(i + D - 1) % D];
                        end
                    end
                end
                n_count = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_empty_error = 1'b1;
            end else begin
                n_popped_value = r_val[0];
                n_popped_valid = 1'b1;
                for (int i = 0; i < D - 1; i++) begin
                    n_val[i] = r_val[i+1];
                    n_pri[i] = r_pri[i+1];
                end
                n_count = r_count - 1'b1;
            end
        end
        n_head_value = (n_count != '0) ? n_val[0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_in_value <= i_value;
            r_in_prio  <= spq_pkg::t_prio'(i_priority_req);
        end
        if (i_cmd.exec) begin
            for (int i = 0; i < D; i++) begin
                r_val[i] <= n_val[i];
                r_pri[i] <= n_pri[i];
            end
            r_popped_value <= n_popped_value;
            r_popped_valid <= n_popped_valid;
            r_empty_error  <= n_empty_error;
            r_full_error   <= n_full_error;
            r_head_value   <= n_head_value;
            r_entry_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_popped_value = r_popped_value;
    assign o_popped_valid = r_popped_valid;
    assign o_empty_error  = r_empty_error;
    assign o_full_error   = r_full_error;
    assign o_head_value   = r_head_value;
    assign o_entry_count  = r_entry_count;

endmodule

`default_nettype wire

[design/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue: sorted-list priority queue with stable ordering
// Push inserts after all entries of equal or lower priority number; pop
// removes the head. Each transfer in yields one result transfer out.
// ----------------------------------------------------------------------------
// Result: the item is captured at the input transfer and then applied;
//   o_valid rises with the apply, which waits while an earlier result is held.
// Input: the next item is taken only once the held one has been applied, as
//   the controller's capture/apply sequence sets; all slots update in parallel.
// A new item is taken while a finished result still waits at the output.
// Reset (i_rst_n low, synchronous) empties the queue and clears o_valid;
//   slot contents are left as they are and never read beyond the count.
`default_nettype none

module stable_priority_queue (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic                               i_func,
    input  wire logic signed [spq_pkg::VALUE_W-1:0] i_value,
    input  wire logic [spq_pkg::PRIO_IN_W-1:0]      i_priority_req,
    // result channel
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [spq_pkg::VALUE_W-1:0]      o_popped_value,
    output logic                                    o_popped_valid,
    output logic                                    o_empty_error,
    output logic                                    o_full_error,
    output logic signed [spq_pkg::VALUE_W-1:0]      o_head_value,
    output logic [spq_pkg::CNT_W-1:0]               o_entry_count
);

    spq_pkg::t_dp_cmd cmd;

    // Sequencer: accept in idle, apply the item once the result register
    // is free (empty or being drained this cycle), then hold the result.
    spq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // Slot array, fill count and result register.
    spq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .o_popped_value (o_popped_value),
        .o_popped_valid (o_popped_valid),
        .o_empty_error  (o_empty_error),
        .o_full_error   (o_full_error),
        .o_head_value   (o_head_value),
        .o_entry_count  (o_entry_count)
    );

endmodule

`default_nettype wire

[tb/tb_stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_stable_priority_queue: self-checking bench for the stable priority queue
// Sends push and pop operations through the valid/ready input channel,
// tracks the sorted contents in a shadow copy and compares every result
// transfer field by field. The directed part covers empty pops, value and
// priority extremes, ties and a dropped push on a full queue. The random
// part runs in phases that favor filling, draining or a balanced mix.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stable_priority_queue;

    localparam int DEPTH        = spq_pkg::DEPTH;
    localparam int PRIO_IN_W    = spq_pkg::PRIO_IN_W;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 730;

    typedef struct {
        spq_pkg::t_value popped_value;
        logic            popped_valid;
        logic            empty_error;
        logic            full_error;
        spq_pkg::t_value head_value;
        spq_pkg::t_count entry_count;
    } t_queue_result;

    // DUT ports; every input starts at a known value
    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_ready;
    logic                 i_func         = spq_pkg::FUNC_PUSH;
    spq_pkg::t_value      i_value        = '0;
    logic [PRIO_IN_W-1:0] i_priority_req = '0;
    logic                 o_valid;
    logic                 i_ready        = 1'b0;
    spq_pkg::t_value      o_popped_value;
    logic                 o_popped_valid;
    logic                 o_empty_error;
    logic                 o_full_error;
    spq_pkg::t_value      o_head_value;
    spq_pkg::t_count      o_entry_count;

    // Shadow copy of the sorted slots, head at index 0
    spq_pkg::t_value shadow_values [DEPTH];
    spq_pkg::t_prio  shadow_prios  [DEPTH];
    int              shadow_count = 0;

    t_queue_result pending_results [$];

    int mismatch_count = 0;
    int burst_left     = 0;
    int cycle_count    = 0;
    logic [9:0] rx_cycle = '0;

    stable_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_popped_value (o_popped_value),
        .o_popped_valid (o_popped_valid),
        .o_empty_error  (o_empty_error),
        .o_full_error   (o_full_error),
        .o_head_value   (o_head_value),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one accepted operation to the shadow queue and return the result
    // the block must report for it.
    function automatic t_queue_result next_queue_result(input logic func,
                                                        input spq_pkg::t_value value,
                                                        input logic [PRIO_IN_W-1:0] prio_req);
        t_queue_result  res;
        spq_pkg::t_prio prio;
        int             pos;
        prio = spq_pkg::t_prio'(prio_req);   // drop priority bits above PRIO_BITS
        res.popped_value = '0;
        res.popped_valid = 1'b0;
        res.empty_error  = 1'b0;
        res.full_error   = 1'b0;
        if (func == spq_pkg::FUNC_PUSH) begin
            if (shadow_count >= DEPTH) begin
                res.full_error = 1'b1;
            end else begin
                // Insert after every entry whose priority is not greater
                pos = 0;
                while (pos < shadow_count && shadow_prios[pos] <= prio)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_values[i] = shadow_values[i-1];
                    shadow_prios[i]  = shadow_prios[i-1];
                end
                shadow_values[pos] = value;
                shadow_prios[pos]  = prio;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.empty_error = 1'b1;
            end else begin
                res.popped_value = shadow_values[0];
                res.popped_valid = 1'b1;
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_values[i-1] = shadow_values[i];
                    shadow_prios[i-1]  = shadow_prios[i];
                end
                shadow_count--;
            end
        end
        res.head_value  = (shadow_count > 0) ? shadow_values[0] : '0;
        res.entry_count = spq_pkg::t_count'(shadow_count);
        return res;
    endfunction

    // Send one operation. The sender works in bursts; at the start of a burst
    // drop valid for a random gap, otherwise keep it high into the next item.
    task automatic send_op(input logic func, input spq_pkg::t_value value,
                           input logic [PRIO_IN_W-1:0] prio_req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_func         <= func;
        i_value        <= value;
        i_priority_req <= prio_req;
        // Hold the payload until the transfer
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(next_queue_result(func, value, prio_req));
    endtask

    // Hold off the sender until every expected result has come out
    task automatic wait_for_results();
        i_valid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_empty_pop();
        send_op(spq_pkg::FUNC_POP, 32'sd0, '0);
        send_op(spq_pkg::FUNC_POP, 32'sh7FFF_FFFF, 16'hFFFF);
    endtask

    // Fill with extreme values and priorities, ties at both ends of the
    // priority range, then push once more to hit the full case.
    task automatic test_fill_to_full();
        spq_pkg::t_value      fill_values [16] = '{
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
            32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001, 32'sh0000_0002,
            32'sh0000_0003, 32'sh1234_5678, 32'shFEDC_BA98, 32'sh0F0F_0F0F,
            32'shF0F0_F0F0, 32'sh0000_0004, 32'sh0000_0005, 32'sh0000_0006};
        logic [PRIO_IN_W-1:0] fill_prios [16] = '{
            16'hFFFF, 16'h0000, 16'h0005, 16'h0005, 16'h0005, 16'h0000,
            16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'h0005, 16'hAAAA,
            16'h5555, 16'h0000, 16'hFFFF, 16'h0003};
        for (int i = 0; i < 16; i++)
            send_op(spq_pkg::FUNC_PUSH, fill_values[i], fill_prios[i]);
        send_op(spq_pkg::FUNC_PUSH, 32'sh1357_9BDF, 16'h0000);
    endtask

    task automatic test_partial_drain();
        repeat (4) send_op(spq_pkg::FUNC_POP, 32'sd0, '0);
    endtask

    // Random phases: push-heavy, pop-heavy or balanced, with priorities that
    // are either spread over the full range or packed into a few values near
    // zero or near the top so that ties are frequent.
    task automatic test_random_traffic(input int n_items);
        int                   sent = 0;
        int                   phase_len;
        int                   push_pct;
        bit                   narrow;
        logic [PRIO_IN_W-1:0] prio_base;
        logic [PRIO_IN_W-1:0] prio;
        logic                 func;
        while (sent < n_items) begin
            phase_len = $urandom_range(10, 60);
            if (phase_len > n_items - sent)
                phase_len = n_items - sent;
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            narrow    = $urandom_range(0, 1);
            prio_base = $urandom_range(0, 1) ? 16'hFFFC : 16'h0000;
            repeat (phase_len) begin
                func = ($urandom_range(1, 100) <= push_pct) ? spq_pkg::FUNC_PUSH
                                                            : spq_pkg::FUNC_POP;
                prio = narrow ? prio_base + PRIO_IN_W'($urandom_range(0, 3))
                              : PRIO_IN_W'($urandom_range(0, 16'hFFFF));
                send_op(func, spq_pkg::t_value'($urandom), prio);
            end
            sent += phase_len;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver: stall on its own pattern, switching style with bits 9:8 of rx_cycle
    // between always ready, coin flips, long stalls and rare stalls.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[9:8])
            2'd0:    i_ready <= 1'b1;
            2'd1:    i_ready <= ($urandom_range(0, 1) == 0);
            2'd2:    i_ready <= (rx_cycle[3:0] < 4'd3);
            default: i_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_queue_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual head %h count %0d",
                         $time, o_head_value, o_entry_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("popped_value", want.popped_value, o_popped_value);
                check_field("popped_valid", want.popped_valid, o_popped_valid);
                check_field("empty_error",  want.empty_error,  o_empty_error);
                check_field("full_error",   want.full_error,   o_full_error);
                check_field("head_value",   want.head_value,   o_head_value);
                check_field("entry_count",  want.entry_count,  o_entry_count);
            end
        end
    end

    // Watchdog: end a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pop();
        test_fill_to_full();
        test_partial_drain();
        // Let the queue settle once before the random part
        wait_for_results();
        test_random_traffic(RANDOM_ITEMS / 2);
        wait_for_results();
        test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2);

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/stable_priority_queue.sv
tb/tb_stable_priority_queue.sv
